// ===== src/fwsx_pkg.sv =====
// Shared types, constants and helper functions for the four-word shift-xor generator.
// Used by the front, queue, back and top-level modules; depends on nothing.
`timescale 1ns / 1ps

package fwsx_pkg;

	localparam int WORD_W = 32;
	localparam int FRAC_W = 24;
	localparam int STEP_W = 5;	// counts the 32 remainder steps

	// Request kinds carried on s_tuser.
	localparam logic [1:0] OP_RAW    = 2'd0;
	localparam logic [1:0] OP_RANGE  = 2'd1;
	localparam logic [1:0] OP_RESEED = 2'd2;

	// Seed scrambling constants.
	localparam logic [WORD_W-1:0] SEED_XOR0 = 32'h0AED_1A0C;
	localparam logic [WORD_W-1:0] SEED_XOR1 = 32'hAA5A_02FE;
	localparam logic [WORD_W-1:0] SEED_XOR2 = 32'h11BE_81C7;

	typedef logic [WORD_W-1:0] word_t;

	// One drawn word waiting for the back end.
	typedef struct packed {
		logic  is_range;
		word_t word;
		word_t limit;
	} entry_t;

	// Front end to queue: write request.
	typedef struct packed {
		logic   valid;
		entry_t entry;
	} push_t;

	// Queue status seen by both ends.
	typedef struct packed {
		logic full;
		logic empty;
	} queue_stat_t;

	// Back-end sequencer states.
	typedef enum logic [1:0] {
		BK_IDLE,
		BK_DIV,
		BK_DONE
	} back_state_t;

	function automatic word_t rotr8(input word_t v);
		return {v[7:0], v[WORD_W-1:8]};
	endfunction

	// New word from the four state words (w0 newest).
	function automatic word_t draw_next(input word_t w0, input word_t w1,
			input word_t w2, input word_t w3);
		word_t left;
		word_t right;
		left  = {w1[WORD_W-3:0], w0[WORD_W-1:WORD_W-2]};
		right = {w3[WORD_W-2:0], w2[WORD_W-1]};
		return left ^ right;
	endfunction

endpackage

// ===== src/four_word_shift_xor_rng.sv =====
// Top level of the four-word shift-xor generator: front end, queue and back end.
// Depends on fwsx_pkg, fwsx_front, fwsx_queue and fwsx_back.
//
//   channel | direction | tdata                           | tuser
//   s_*     | in        | range_limit[31:0] seed[63:32]   | operation[1:0]
//   m_*     | out       | value[31:0] fraction[55:32]     | divide_error[0]
//
// A request is taken whenever the queue has room; a reseed reloads the
// state words, an unused code leaves them alone, and neither produces more.
// A draw is written into the queue, popped by the back end in its idle
// state and loaded into the output register from its done state; a range
// draw with a non-zero limit first passes through the one-bit-per-cycle
// remainder unit, while a raw or zero-limit range draw skips it.
// Reset zeroes the state words, empties queue and output register at once.
// A stalled output only holds the back end; the front keeps taking requests
// until the queue of QUEUE_DEPTH entries is full.
`timescale 1ns / 1ps

module four_word_shift_xor_rng #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,	// range_limit [31:0], seed_value [63:32]
	input  logic [1:0]  s_tuser,	// operation [1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [55:0] m_tdata,	// value [31:0], fraction [55:32]
	output logic        m_tuser	// divide_error [0]
);

	fwsx_pkg::push_t       push;
	fwsx_pkg::entry_t      head;
	fwsx_pkg::queue_stat_t q_stat;
	logic                  pop;
	logic [$clog2(QUEUE_DEPTH+1)-1:0] q_count;

	// Request intake and generator state.
	fwsx_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.q_stat   (q_stat),
		.push     (push)
	);

	// Decoupling queue of drawn words.
	fwsx_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.pop    (pop),
		.head   (head),
		.q_stat (q_stat),
		.count  (q_count)
	);

	// Remainder unit and output register.
	fwsx_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (head),
		.q_stat   (q_stat),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	// The queue never holds more than its depth.
	assert property (@(posedge clk) disable iff (!arst_n)
		q_count <= ($clog2(QUEUE_DEPTH+1))'(QUEUE_DEPTH))
	else $error("queue fill count beyond depth");

	// The back end only reads an entry that is present.
	assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !q_stat.empty)
	else $error("queue read while empty");

	// A flagged zero-limit result always carries a zero value.
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser) |-> (m_tdata[31:0] == '0))
	else $error("divide error with non-zero value");

endmodule

// ===== src/fwsx_front.sv =====
// Front end: accepts requests, holds the four state words, performs draws and reseeds.
// Depends on fwsx_pkg; feeds drawn words into fwsx_queue.
`timescale 1ns / 1ps

module fwsx_front (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [63:0]            s_tdata,	// range_limit [31:0], seed_value [63:32]
	input  logic [1:0]             s_tuser,	// operation [1:0]
	input  fwsx_pkg::queue_stat_t  q_stat,
	output fwsx_pkg::push_t        push
);

	fwsx_pkg::word_t gen_q [4];
	fwsx_pkg::word_t fresh;
	fwsx_pkg::word_t seed_t0;
	fwsx_pkg::word_t seed_t1;
	fwsx_pkg::word_t seed_t2;
	logic            accept;

	// A request is taken whenever the queue has room for a drawn word.
	assign s_tready = !q_stat.full;
	assign accept   = s_tvalid && s_tready;

	// Next word and the seed expansion chain.
	always_comb begin
		fresh   = fwsx_pkg::draw_next(gen_q[0], gen_q[1], gen_q[2], gen_q[3]);
		seed_t0 = s_tdata[63:32] ^ fwsx_pkg::SEED_XOR0;
		seed_t1 = fwsx_pkg::rotr8(seed_t0);
		seed_t2 = fwsx_pkg::rotr8(seed_t1 ^ fwsx_pkg::SEED_XOR1);
	end

	// State words: shift on a draw, reload on a reseed.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 4; i++) gen_q[i] <= '0;
		end else if (accept) begin
			unique case (s_tuser)
				fwsx_pkg::OP_RAW, fwsx_pkg::OP_RANGE: begin
					gen_q[0] <= fresh;
					gen_q[1] <= gen_q[0];
					gen_q[2] <= gen_q[1];
					gen_q[3] <= gen_q[2];
				end
				fwsx_pkg::OP_RESEED: begin
					gen_q[0] <= seed_t0;
					gen_q[1] <= seed_t1;
					gen_q[2] <= seed_t2;
					gen_q[3] <= fwsx_pkg::rotr8(seed_t2 ^ fwsx_pkg::SEED_XOR2);
				end
				default: begin
				end
			endcase
		end
	end

	// Only draws produce work for the back end.
	always_comb begin
		push.valid          = accept && (s_tuser == fwsx_pkg::OP_RAW ||
		                                 s_tuser == fwsx_pkg::OP_RANGE);
		push.entry.is_range = (s_tuser == fwsx_pkg::OP_RANGE);
		push.entry.word     = fresh;
		push.entry.limit    = s_tdata[31:0];
	end

endmodule

// ===== src/fwsx_queue.sv =====
// Short first-in first-out queue of drawn words between front and back ends.
// Depends on fwsx_pkg for the entry and status types.
`timescale 1ns / 1ps

module fwsx_queue #(
	parameter int DEPTH = 2
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  fwsx_pkg::push_t       push,
	input  logic                  pop,
	output fwsx_pkg::entry_t      head,
	output fwsx_pkg::queue_stat_t q_stat,
	output logic [$clog2(DEPTH+1)-1:0] count
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(DEPTH);

	fwsx_pkg::entry_t   mem_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;

	assign head         = mem_q[rd_ptr_q];
	assign q_stat.full  = (count_q == FULL_COUNT);
	assign q_stat.empty = (count_q == '0);
	assign count        = count_q;

	// Entry storage; writes only happen while there is room.
	always_ff @(posedge clk) begin
		if (push.valid) mem_q[wr_ptr_q] <= push.entry;
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push.valid) wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + 1'b1;
			if (pop) rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + 1'b1;
			if (push.valid && !pop) count_q <= count_q + 1'b1;
			else if (pop && !push.valid) count_q <= count_q - 1'b1;
		end
	end

endmodule

// ===== src/fwsx_back.sv =====
// Back end: takes drawn words from the queue, reduces range draws bit-serially,
// and holds each result in the output register. Depends on fwsx_pkg.
`timescale 1ns / 1ps

module fwsx_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  fwsx_pkg::entry_t      head,
	input  fwsx_pkg::queue_stat_t q_stat,
	output logic                  pop,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [55:0]           m_tdata,	// value [31:0], fraction [55:32]
	output logic                  m_tuser	// divide_error [0]
);

	fwsx_pkg::back_state_t state_q;
	fwsx_pkg::back_state_t state_d;

	logic                        is_range_q;
	fwsx_pkg::word_t             word_q;
	fwsx_pkg::word_t             limit_q;
	fwsx_pkg::word_t             dvd_q;
	fwsx_pkg::word_t             rem_q;
	logic [fwsx_pkg::STEP_W-1:0] step_q;

	logic                        out_valid_q;
	fwsx_pkg::word_t             out_value_q;
	logic [fwsx_pkg::FRAC_W-1:0] out_frac_q;
	logic                        out_err_q;

	logic                        load_out;
	logic                        limit_zero;
	logic [fwsx_pkg::WORD_W:0]   trial;
	logic [fwsx_pkg::WORD_W:0]   diff;

	assign limit_zero = (limit_q == '0);

	// One restoring remainder step: bring down the next dividend bit.
	always_comb begin
		trial = {rem_q, dvd_q[fwsx_pkg::WORD_W-1]};
		diff  = trial - {1'b0, limit_q};
	end

	// Next-state logic of the back-end sequencer.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			fwsx_pkg::BK_IDLE: begin
				if (!q_stat.empty) begin
					state_d = (head.is_range && head.limit != '0) ?
					          fwsx_pkg::BK_DIV : fwsx_pkg::BK_DONE;
				end
			end
			fwsx_pkg::BK_DIV: begin
				if (step_q == '0) state_d = fwsx_pkg::BK_DONE;
			end
			fwsx_pkg::BK_DONE: begin
				if (!out_valid_q || m_tready) state_d = fwsx_pkg::BK_IDLE;
			end
			default: state_d = fwsx_pkg::BK_IDLE;
		endcase
	end

	// Control outputs of the sequencer.
	always_comb begin
		pop      = 1'b0;
		load_out = 1'b0;
		unique case (state_q)
			fwsx_pkg::BK_IDLE: pop      = !q_stat.empty;
			fwsx_pkg::BK_DONE: load_out = !out_valid_q || m_tready;
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= fwsx_pkg::BK_IDLE;
		else state_q <= state_d;
	end

	// Working registers of the remainder unit.
	always_ff @(posedge clk) begin
		if (pop) begin
			is_range_q <= head.is_range;
			word_q     <= head.word;
			limit_q    <= head.limit;
			dvd_q      <= head.word;
			rem_q      <= '0;
			step_q     <= '1;
		end else if (state_q == fwsx_pkg::BK_DIV) begin
			rem_q  <= diff[fwsx_pkg::WORD_W] ? trial[fwsx_pkg::WORD_W-1:0]
			                                 : diff[fwsx_pkg::WORD_W-1:0];
			dvd_q  <= {dvd_q[fwsx_pkg::WORD_W-2:0], 1'b0};
			step_q <= step_q - 1'b1;
		end
	end

	// Output register; a new result may load as the old one is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_frac_q  <= word_q[fwsx_pkg::FRAC_W-1:0];
			out_err_q   <= is_range_q && limit_zero;
			if (!is_range_q) out_value_q <= word_q;
			else if (limit_zero) out_value_q <= '0;
			else out_value_q <= rem_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {out_frac_q, out_value_q};
	assign m_tuser  = out_err_q;

endmodule

// ===== verif/four_word_shift_xor_rng_tb.sv =====
// Self-checking testbench for the four-word shift-xor generator: a directed table, then random requests.
// Results are held to an in-bench predictor or a typed row's want; depends on fwsx_pkg and the RTL.
`timescale 1ns / 1ps

module four_word_shift_xor_rng_tb;

	// The one operation code the block ignores.
	localparam logic [1:0] OP_UNUSED = 2'd3;

	localparam int RANDOM_REQUESTS = 1250;
	localparam int HOLD_CYCLES     = 300;
	localparam int DRAIN_CYCLES    = 40;
	localparam int DIRECTED_ROWS   = 22;

	typedef struct packed {
		fwsx_pkg::word_t             value;
		logic [fwsx_pkg::FRAC_W-1:0] fraction;
		logic                        divide_error;
	} result_t;

	// One row of the directed table; want is only used where typed is set.
	typedef struct packed {
		logic [1:0]      op;
		fwsx_pkg::word_t limit;
		fwsx_pkg::word_t seed;
		logic            typed;
		result_t         want;
	} row_t;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [63:0] s_tdata  = '0;
	logic [1:0]  s_tuser  = fwsx_pkg::OP_RAW;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [55:0] m_tdata;
	logic        m_tuser;

	four_word_shift_xor_rng dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always #10 clk = ~clk;

	// Predicted generator state, newest word first, and results still to arrive.
	fwsx_pkg::word_t gen_state [4];
	result_t         pending_results [$];
	int              mismatches    = 0;
	int              send_idle_pct = 0;
	int              recv_idle_pct = 0;
	bit              hold_request  = 1'b0;

	row_t directed_rows [DIRECTED_ROWS] = '{
		// Straight after reset every word is zero, so draws give zero.
		'{fwsx_pkg::OP_RAW,    32'h0000_0000, 32'h0000_0000, 1'b1, '{32'h0, 24'h0, 1'b0}},
		'{fwsx_pkg::OP_RANGE,  32'h0000_0000, 32'h0000_0000, 1'b1, '{32'h0, 24'h0, 1'b1}},
		'{fwsx_pkg::OP_RANGE,  32'hFFFF_FFFF, 32'h0000_0000, 1'b1, '{32'h0, 24'h0, 1'b0}},
		'{OP_UNUSED,           32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, '0},
		'{fwsx_pkg::OP_RAW,    32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, '{32'h0, 24'h0, 1'b0}},
		'{fwsx_pkg::OP_RESEED, 32'h0000_0000, 32'h0000_0000, 1'b0, '0},
		'{fwsx_pkg::OP_RAW,    32'h0000_0000, 32'hFFFF_FFFF, 1'b0, '0},
		'{fwsx_pkg::OP_RANGE,  32'h0000_0001, 32'h0000_0000, 1'b0, '0},
		'{fwsx_pkg::OP_RANGE,  32'hFFFF_FFFF, 32'h0000_0000, 1'b0, '0},
		'{fwsx_pkg::OP_RANGE,  32'h0000_0000, 32'h0000_0000, 1'b0, '0},
		'{fwsx_pkg::OP_RANGE,  32'h8000_0000, 32'h0000_0000, 1'b0, '0},
		'{fwsx_pkg::OP_RESEED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, '0},
		'{fwsx_pkg::OP_RAW,    32'h0000_0000, 32'h0000_0000, 1'b0, '0},
		'{fwsx_pkg::OP_RAW,    32'h0000_0000, 32'h0000_0000, 1'b0, '0},
		// An ignored code in the middle of a run must leave the state alone.
		'{OP_UNUSED,           32'h0000_0000, 32'h0000_0000, 1'b0, '0},
		'{fwsx_pkg::OP_RAW,    32'h0000_0000, 32'h0000_0000, 1'b0, '0},
		'{fwsx_pkg::OP_RANGE,  32'h0000_0007, 32'h0000_0000, 1'b0, '0},
		// This seed cancels the first xor, leaving the two newest words zero.
		'{fwsx_pkg::OP_RESEED, 32'h0000_0000, fwsx_pkg::SEED_XOR0, 1'b0, '0},
		'{fwsx_pkg::OP_RAW,    32'h0000_0000, 32'h0000_0000, 1'b0, '0},
		'{fwsx_pkg::OP_RANGE,  32'h0000_0002, 32'h0000_0000, 1'b0, '0},
		'{fwsx_pkg::OP_RESEED, 32'h0000_0000, 32'h1234_5678, 1'b0, '0},
		'{fwsx_pkg::OP_RANGE,  32'hFFFF_FFFE, 32'h0000_0000, 1'b0, '0}
	};

	function automatic fwsx_pkg::word_t rotate_word_right8(input fwsx_pkg::word_t v);
		return (v >> 8) | (v << 24);
	endfunction

	// Advances the predicted state for one request and works out its result, if any.
	task automatic predict_request(input logic [1:0] op, input fwsx_pkg::word_t limit,
			input fwsx_pkg::word_t seed, output bit produces, output result_t res);
		fwsx_pkg::word_t fresh;
		fwsx_pkg::word_t t;
		produces = 1'b0;
		res      = '0;
		case (op)
		fwsx_pkg::OP_RESEED: begin
			t = seed ^ fwsx_pkg::SEED_XOR0;
			gen_state[0] = t;
			t = rotate_word_right8(t);
			gen_state[1] = t;
			t = rotate_word_right8(t ^ fwsx_pkg::SEED_XOR1);
			gen_state[2] = t;
			gen_state[3] = rotate_word_right8(t ^ fwsx_pkg::SEED_XOR2);
		end
		fwsx_pkg::OP_RAW, fwsx_pkg::OP_RANGE: begin
			fresh = ((gen_state[1] << 2) | (gen_state[0] >> 30))
				^ ((gen_state[3] << 1) | (gen_state[2] >> 31));
			gen_state[3] = gen_state[2];
			gen_state[2] = gen_state[1];
			gen_state[1] = gen_state[0];
			gen_state[0] = fresh;
			produces         = 1'b1;
			res.value        = fresh;
			res.fraction     = fresh[fwsx_pkg::FRAC_W-1:0];
			res.divide_error = 1'b0;
			if (op == fwsx_pkg::OP_RANGE) begin
				if (limit == '0) begin
					res.value        = '0;
					res.divide_error = 1'b1;
				end else begin
					res.value = fresh % limit;
				end
			end
		end
		default: ;
		endcase
	endtask

	// Offers one request after a random gap and waits until the block takes it.
	task automatic send_request(input logic [1:0] op, input fwsx_pkg::word_t limit,
			input fwsx_pkg::word_t seed, input bit typed, input result_t want);
		bit      produces;
		result_t res;
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {seed, limit};
		s_tuser  <= op;
		do @(posedge clk); while (!s_tready);
		predict_request(op, limit, seed, produces, res);
		if (produces)
			pending_results.push_back(typed ? want : res);
	endtask

	// Stops offering requests until every predicted result has been received.
	task automatic wait_for_drain();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (pending_results.size() != 0);
	endtask

	function automatic fwsx_pkg::word_t pick_limit();
		case ($urandom_range(9))
		0:       return '0;
		1:       return $urandom_range(16, 1);
		2:       return 32'h1 << $urandom_range(31);
		3:       return 32'hFFFF_FFFF - $urandom_range(15);
		4:       return $urandom_range(255);
		default: return $urandom();
		endcase
	endfunction

	// Receiver: checks each accepted result, then decides whether to stall next cycle.
	initial begin
		int      hold_left;
		result_t got;
		result_t want;
		hold_left = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready) begin
				got = '{m_tdata[31:0], m_tdata[55:32], m_tuser};
				if (pending_results.size() == 0) begin
					$error("unexpected result: value %h fraction %h divide_error %b",
						got.value, got.fraction, got.divide_error);
					mismatches++;
				end else begin
					want = pending_results.pop_front();
					if (got.value !== want.value) begin
						$error("value: expected %h, got %h", want.value, got.value);
						mismatches++;
					end
					if (got.fraction !== want.fraction) begin
						$error("fraction: expected %h, got %h", want.fraction, got.fraction);
						mismatches++;
					end
					if (got.divide_error !== want.divide_error) begin
						$error("divide_error: expected %b, got %b",
							want.divide_error, got.divide_error);
						mismatches++;
					end
				end
			end
			if (hold_request) begin
				hold_left    = HOLD_CYCLES;
				hold_request = 1'b0;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	// Sender: reset, directed table, then random requests through the idling phases.
	initial begin
		int         counted;
		bit         hold_done;
		bit         pause_done;
		logic [1:0] op;
		int         pick;
		counted    = 0;
		hold_done  = 1'b0;
		pause_done = 1'b0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(posedge clk);

		foreach (directed_rows[i])
			send_request(directed_rows[i].op, directed_rows[i].limit, directed_rows[i].seed,
				directed_rows[i].typed, directed_rows[i].want);
		wait_for_drain();

		while (counted < RANDOM_REQUESTS) begin
			case (counted * 4 / RANDOM_REQUESTS)
			0:       begin send_idle_pct = 0;  recv_idle_pct = 0;  end
			1:       begin send_idle_pct = 77; recv_idle_pct = 0;  end
			2:       begin send_idle_pct = 0;  recv_idle_pct = 77; end
			default: begin send_idle_pct = 32; recv_idle_pct = 32; end
			endcase
			// A long output stall while requests keep coming, so the queue fills.
			if (counted >= 150 && !hold_done) begin
				hold_request = 1'b1;
				hold_done    = 1'b1;
			end
			if (counted >= 700 && !pause_done) begin
				wait_for_drain();
				pause_done = 1'b1;
			end
			pick = $urandom_range(99);
			if (pick < 8)
				op = fwsx_pkg::OP_RESEED;
			else if (pick < 11)
				op = OP_UNUSED;
			else if (pick < 55)
				op = fwsx_pkg::OP_RAW;
			else
				op = fwsx_pkg::OP_RANGE;
			send_request(op, pick_limit(), $urandom(), 1'b0, '0);
			if (op != OP_UNUSED)
				counted++;
		end

		wait_for_drain();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("four_word_shift_xor_rng_tb: done, clean");
		else
			$display("four_word_shift_xor_rng_tb: done, errors");
		$finish;
	end

	// Watchdog: far beyond the slowest correct run.
	initial begin
		#(64'd20_000_000);
		$display("four_word_shift_xor_rng_tb: done, errors");
		$finish;
	end

endmodule

// ===== filelist.f =====
src/fwsx_pkg.sv
src/fwsx_front.sv
src/fwsx_queue.sv
src/fwsx_back.sv
src/four_word_shift_xor_rng.sv
verif/four_word_shift_xor_rng_tb.sv
